[src/hidp_pkg.sv]
// shared types and constants of the hid report descriptor parser
package hidp_pkg;

  localparam logic [7:0] LONG_PREFIX = 8'hFE;

  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  localparam logic [3:0] TAG_INPUT   = 4'd8;
  localparam logic [3:0] TAG_OUTPUT  = 4'd9;
  localparam logic [3:0] TAG_FEATURE = 4'd11;

  localparam logic [3:0] TAG_PAGE    = 4'd0;
  localparam logic [3:0] TAG_LMIN    = 4'd1;
  localparam logic [3:0] TAG_LMAX    = 4'd2;
  localparam logic [3:0] TAG_RSIZE   = 4'd7;
  localparam logic [3:0] TAG_RID     = 4'd8;
  localparam logic [3:0] TAG_RCOUNT  = 4'd9;

  localparam logic [3:0] TAG_USAGE   = 4'd0;
  localparam logic [3:0] TAG_UMIN    = 4'd1;
  localparam logic [3:0] TAG_UMAX    = 4'd2;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;
  localparam logic [1:0] MODE_LIST  = 2'd2;

  localparam logic [2:0] KIND_TOTAL_BASE = 3'd3;

  // parser phase
  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_DATA   = 3'd1,
    PH_LSIZE  = 3'd2,
    PH_LTAG   = 3'd3,
    PH_LDATA  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  report_id;
    logic [31:0] bit_offset;
    logic [31:0] bit_size;
    logic [31:0] field_count;
    logic [31:0] logical_min;
    logic [31:0] logical_max;
    logic [15:0] usage_page;
    logic [1:0]  usage_mode;
    logic [15:0] usage_value;
    logic [15:0] usage_max;
    logic        last_of_run;
  } record_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } desc_in_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       take_byte;    // run byte parse on the held input
    logic       exec_item;    // commit global/local item, load main item plan
    logic       emit_field;   // present a field record
    logic       field_done;   // advance offset, clear locals
    logic       emit_total;   // present a totals record
    logic [1:0] total_kind;
    logic       last_rec;
    logic       clear_all;    // parse reset after last byte
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic item_ready;   // complete item pending after this byte
    logic is_field_item;
    logic more_fields;  // another listed usage follows
  } stat_t;

endpackage

[src/hidp_if.sv]
// valid/ready channel interface
interface hidp_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/hidp_datapath.sv]
// parse state, global/local registers, usage list and record formatting
module hidp_datapath
  import hidp_pkg::*;
#(
  parameter int MAX_USAGES = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  desc_in_t in_item,
  input  cmd_t     cmd,
  output stat_t    stat,
  output record_t  rec
);
  localparam int UW = $clog2(MAX_USAGES + 1);
  localparam int IW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;

  phase_t      phase;
  logic [7:0]  prefix;
  logic [7:0]  bytes_left;
  logic [1:0]  byte_index;
  logic [31:0] accum;
  logic [15:0] page_now;
  logic [31:0] size_now, count_now, min_now, max_now;
  logic [7:0]  id_now;
  logic [15:0] usage_list [MAX_USAGES];
  logic [UW-1:0] usage_fill;
  logic [15:0] range_low, range_high;
  logic        range_seen;
  logic [31:0] offs [3];
  logic        pending;   // an item is complete and waits for execution

  // per-item plan
  logic [1:0]  kind;
  logic [1:0]  mode;
  logic [UW-1:0] lim;
  logic [UW-1:0] idx;
  logic [15:0] uval;
  logic [31:0] prod;

  // byte parse
  logic [1:0]  b_code;
  logic [7:0]  b_n;
  logic [31:0] acc_next;
  logic [1:0]  ity;
  logic [3:0]  itag;
  logic [2:0]  nbytes;
  logic        field_item;
  logic [1:0]  field_kind;

  assign b_code = in_item.data_byte[1:0];
  assign b_n = (b_code == 2'd3) ? 8'd4 : {6'd0, b_code};
  assign acc_next = accum | ({24'd0, in_item.data_byte} << {byte_index, 3'b000});
  assign ity = prefix[3:2];
  assign itag = prefix[7:4];
  assign nbytes = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};

  always_comb begin
    field_item = 1'b0;
    field_kind = 2'd0;
    if (ity == TYPE_MAIN) begin
      if (itag == TAG_INPUT) begin
        field_item = 1'b1; field_kind = 2'd0;
      end else if (itag == TAG_OUTPUT) begin
        field_item = 1'b1; field_kind = 2'd1;
      end else if (itag == TAG_FEATURE) begin
        field_item = 1'b1; field_kind = 2'd2;
      end
    end
  end

  function automatic logic [31:0] sext(input logic [31:0] v, input logic [2:0] n);
    logic [31:0] r;
    case (n)
      3'd0: r = 32'd0;
      3'd1: r = {{24{v[7]}}, v[7:0]};
      3'd2: r = {{16{v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  assign stat.item_ready = pending;
  assign stat.is_field_item = field_item;
  assign stat.more_fields = (mode == MODE_LIST) && ((idx + 1'b1) < lim);

  // usage list read, registered
  always_ff @(posedge clk) begin
    if (cmd.exec_item) uval <= usage_list[0];
    else if (cmd.emit_field) uval <= usage_list[IW'(idx + 1'b1)];
    if (ity == TYPE_LOCAL && itag == TAG_USAGE && cmd.exec_item &&
        usage_fill < UW'(MAX_USAGES))
      usage_list[usage_fill[IW-1:0]] <= accum[15:0];
  end

  logic [UW-1:0] cnt_lim;
  assign cnt_lim = (count_now < {{(32-UW){1'b0}}, usage_fill}) ? count_now[UW-1:0]
                                                                : usage_fill;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      phase <= PH_PREFIX;
      prefix <= '0; bytes_left <= '0; byte_index <= '0; accum <= '0;
      page_now <= '0; size_now <= '0; count_now <= '0;
      min_now <= '0; max_now <= '0; id_now <= '0;
      usage_fill <= '0; range_low <= '0; range_high <= '0; range_seen <= 1'b0;
      offs[0] <= '0; offs[1] <= '0; offs[2] <= '0;
      pending <= 1'b0;
      idx <= '0; mode <= MODE_NONE; kind <= '0; lim <= '0;
    end else begin
      if (cmd.take_byte) begin
        pending <= 1'b0;
        unique case (phase)
          PH_PREFIX: begin
            if (in_item.data_byte == LONG_PREFIX) phase <= PH_LSIZE;
            else begin
              prefix <= in_item.data_byte;
              accum <= '0;
              byte_index <= '0;
              bytes_left <= b_n;
              if (b_n == 8'd0) pending <= 1'b1;
              else phase <= PH_DATA;
            end
          end
          PH_DATA: begin
            accum <= acc_next;
            byte_index <= byte_index + 2'd1;
            bytes_left <= bytes_left - 8'd1;
            if (bytes_left <= 8'd1) begin
              phase <= PH_PREFIX;
              pending <= 1'b1;
            end
          end
          PH_LSIZE: begin
            bytes_left <= in_item.data_byte;
            phase <= PH_LTAG;
          end
          PH_LTAG: phase <= (bytes_left != 8'd0) ? PH_LDATA : PH_PREFIX;
          PH_LDATA: begin
            if (bytes_left > 8'd0) bytes_left <= bytes_left - 8'd1;
            if (bytes_left <= 8'd1) phase <= PH_PREFIX;
          end
          default: phase <= PH_PREFIX;
        endcase
        // truncated short item executes too, also on a prefix that announces data
        if (in_item.last_byte &&
            ((phase == PH_PREFIX && in_item.data_byte != LONG_PREFIX && b_n != 8'd0) ||
             (phase == PH_DATA && bytes_left > 8'd1)))
          pending <= 1'b1;
      end
      if (cmd.exec_item) begin
        pending <= 1'b0;
        if (ity == TYPE_GLOBAL) begin
          case (itag)
            TAG_PAGE:   page_now <= accum[15:0];
            TAG_LMIN:   min_now <= sext(accum, nbytes);
            TAG_LMAX:   max_now <= sext(accum, nbytes);
            TAG_RSIZE:  size_now <= accum;
            TAG_RID:    id_now <= accum[7:0];
            TAG_RCOUNT: count_now <= accum;
            default: ;
          endcase
        end else if (ity == TYPE_LOCAL) begin
          case (itag)
            TAG_USAGE: if (usage_fill < UW'(MAX_USAGES)) usage_fill <= usage_fill + 1'b1;
            TAG_UMIN: begin range_low <= accum[15:0]; range_seen <= 1'b1; end
            TAG_UMAX: begin range_high <= accum[15:0]; range_seen <= 1'b1; end
            default: ;
          endcase
        end
        kind <= field_kind;
        idx <= '0;
        lim <= cnt_lim;
        if (range_seen && range_low <= range_high) mode <= MODE_RANGE;
        else if (cnt_lim == '0) mode <= MODE_NONE;
        else mode <= MODE_LIST;
      end
      if (cmd.emit_field) idx <= idx + 1'b1;
      if (cmd.field_done) begin
        offs[kind] <= offs[kind] + prod;
        usage_fill <= '0; range_low <= '0; range_high <= '0; range_seen <= 1'b0;
      end
    end
  end

  // size*count, registered; globals are stable while an item runs
  always_ff @(posedge clk) prod <= size_now * count_now;

  always_comb begin
    rec = '0;
    if (cmd.emit_total) begin
      rec.record_kind = KIND_TOTAL_BASE + {1'b0, cmd.total_kind};
      rec.bit_offset = offs[cmd.total_kind];
    end else begin
      rec.record_kind = {1'b0, kind};
      rec.report_id = id_now;
      rec.bit_offset = offs[kind];
      rec.bit_size = size_now;
      rec.field_count = count_now;
      rec.logical_min = min_now;
      rec.logical_max = max_now;
      rec.usage_page = page_now;
      rec.usage_mode = mode;
      if (mode == MODE_RANGE) begin
        rec.usage_value = range_low;
        rec.usage_max = range_high;
      end else if (mode == MODE_LIST) rec.usage_value = uval;
    end
    rec.last_of_run = cmd.last_rec;
  end

endmodule

[src/hidp_ctrl.sv]
// sequencing of byte parse, item execution and record emission
module hidp_ctrl
  import hidp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_last,
  output logic     out_valid,
  input  logic     out_ready,
  input  stat_t    stat,
  output cmd_t     cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_PLAN  = 6'b000100,
    S_FIELD = 6'b001000,
    S_TOTAL = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic last_held;
  logic [1:0] tk;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid = 1'b0;
    cmd.total_kind = tk;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.take_byte = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.item_ready) begin
          cmd.exec_item = 1'b1;
          state_next = stat.is_field_item ? S_PLAN : (last_held ? S_TOTAL : S_IDLE);
        end else state_next = last_held ? S_TOTAL : S_IDLE;
      end
      // product and first listed usage settle here
      S_PLAN: state_next = S_FIELD;
      S_FIELD: begin
        out_valid = 1'b1;
        cmd.last_rec = !stat.more_fields && !last_held;
        if (out_ready) begin
          cmd.emit_field = 1'b1;
          if (!stat.more_fields) begin
            cmd.field_done = 1'b1;
            state_next = last_held ? S_TOTAL : S_IDLE;
          end
        end
      end
      S_TOTAL: begin
        out_valid = 1'b1;
        cmd.emit_total = 1'b1;
        cmd.last_rec = (tk == 2'd2);
        if (out_ready && tk == 2'd2) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.clear_all = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last_held <= 1'b0;
      tk <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) last_held <= in_last;
      if (state == S_TOTAL && out_ready) tk <= tk + 2'd1;
      if (state == S_DONE) tk <= '0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while a record is shown");
  a_total_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOTAL && out_ready && tk == 2'd2) |=> state == S_DONE)
    else $error("totals did not end the parse");
  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    cmd.exec_item |=> !cmd.exec_item) else $error("item executed twice");

endmodule

[src/hid_report_descriptor_parser.sv]
// hid report descriptor parser, top level
// One descriptor byte is taken per transaction, parsed and then executed; an
// Input, Output or Feature item then shows one record per listed usage, or one
// for a usage range or none (after a setup state, up to MAX_USAGES records),
// and a byte flagged last adds three totals records and a one-cycle parse reset.
// The rate is set by the controller, which handles one byte at a time and
// presents records straight from the datapath registers.
module hid_report_descriptor_parser
  import hidp_pkg::*;
#(
  parameter int MAX_USAGES = 16
) (
  input logic clk,
  input logic rst,
  hidp_if.sink   desc_in,
  hidp_if.source rec_out
);
  cmd_t  cmd;
  stat_t stat;
  record_t rec;

  hidp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (desc_in.valid),
    .in_ready (desc_in.ready),
    .in_last  (desc_in.payload.last_byte),
    .out_valid(rec_out.valid),
    .out_ready(rec_out.ready),
    .stat, .cmd
  );

  hidp_datapath #(.MAX_USAGES(MAX_USAGES)) u_dp (
    .clk, .rst,
    .in_item(desc_in.payload),
    .cmd, .stat, .rec
  );

  assign rec_out.payload = rec;

endmodule

[tb/hid_report_descriptor_parser_tb.sv]
// testbench for the hid report descriptor parser: directed and random descriptors against a predictor
module hid_report_descriptor_parser_tb;
  import hidp_pkg::*;

  localparam int NUM_USAGES = 16;
  localparam int IDLE_LIMIT = 20000;

  // holds expected field and totals records and compares accepted ones
  class record_scoreboard;
    record_t pending[$];
    int errors;

    function void note_record(record_t r);
      pending.insert(pending.size(), r);
    endfunction

    task report(string msg);
      $display("%s", msg);
      errors++;
    endtask

    task check_record(record_t got);
      record_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected record kind=%0d off=%0d", got.record_kind,
                         got.bit_offset));
        return;
      end
      want = pending.pop_front();
      if (got !== want) report($sformatf("record mismatch: got %h want %h", got, want));
    endtask
  endclass

  logic clk;
  logic rst;
  hidp_if #(.T(desc_in_t)) desc_in (clk);
  hidp_if #(.T(record_t)) rec_out (clk);

  hid_report_descriptor_parser #(.MAX_USAGES(NUM_USAGES)) dut (
    .clk(clk),
    .rst(rst),
    .desc_in(desc_in.sink),
    .rec_out(rec_out.source)
  );

  record_scoreboard sb;

  // predictor state
  phase_t      ph;
  logic [7:0]  pfx;
  logic [7:0]  left_cnt;
  logic [1:0]  bidx;
  logic [31:0] accum;
  logic [15:0] page_q;
  logic [31:0] size_q, count_q, min_q, max_q;
  logic [7:0]  id_q;
  logic [15:0] usages [NUM_USAGES];
  int          fill_q;
  logic [15:0] rlow_q, rhigh_q;
  logic        rseen_q;
  logic [31:0] offs [3];
  record_t     out_batch[$];

  function void clear_parse();
    ph = PH_PREFIX; pfx = 0; left_cnt = 0; bidx = 0; accum = 0;
    page_q = 0; size_q = 0; count_q = 0; min_q = 0; max_q = 0; id_q = 0;
    fill_q = 0; rlow_q = 0; rhigh_q = 0; rseen_q = 0;
    for (int k = 0; k < 3; k++) offs[k] = 0;
  endfunction

  function logic [31:0] sign_ext(logic [31:0] v, int nb);
    if (nb == 0) return 0;
    if (nb == 1) return {{24{v[7]}}, v[7:0]};
    if (nb == 2) return {{16{v[15]}}, v[15:0]};
    return v;
  endfunction

  function void push_rec(logic [2:0] kind, logic [7:0] id, logic [31:0] off, logic [31:0] sz,
                         logic [31:0] cnt, logic [31:0] mn, logic [31:0] mx,
                         logic [15:0] page, logic [1:0] mode, logic [15:0] val,
                         logic [15:0] umax);
    record_t r;
    r = '{kind, id, off, sz, cnt, mn, mx, page, mode, val, umax, 1'b0};
    out_batch.insert(out_batch.size(), r);
  endfunction

  function void exec_item();
    logic [1:0] code, typ;
    logic [3:0] tag;
    int nb, kind, lim;
    logic [31:0] off;
    code = pfx[1:0];
    typ = pfx[3:2];
    tag = pfx[7:4];
    nb = (code == 3) ? 4 : code;
    if (typ == TYPE_MAIN) begin
      if (tag == TAG_INPUT) kind = 0;
      else if (tag == TAG_OUTPUT) kind = 1;
      else if (tag == TAG_FEATURE) kind = 2;
      else return;
      off = offs[kind];
      if (rseen_q && rlow_q <= rhigh_q) begin
        push_rec(kind, id_q, off, size_q, count_q, min_q, max_q, page_q, MODE_RANGE,
                 rlow_q, rhigh_q);
      end else begin
        lim = (count_q < fill_q) ? int'(count_q) : fill_q;
        if (lim == 0)
          push_rec(kind, id_q, off, size_q, count_q, min_q, max_q, page_q, MODE_NONE, 0, 0);
        for (int i = 0; i < lim; i++)
          push_rec(kind, id_q, off, size_q, count_q, min_q, max_q, page_q, MODE_LIST,
                   usages[i], 0);
      end
      offs[kind] = off + size_q * count_q;
      fill_q = 0; rlow_q = 0; rhigh_q = 0; rseen_q = 0;
    end else if (typ == TYPE_GLOBAL) begin
      case (tag)
        TAG_PAGE:   page_q = accum[15:0];
        TAG_LMIN:   min_q = sign_ext(accum, nb);
        TAG_LMAX:   max_q = sign_ext(accum, nb);
        TAG_RSIZE:  size_q = accum;
        TAG_RID:    id_q = accum[7:0];
        TAG_RCOUNT: count_q = accum;
        default: ;
      endcase
    end else if (typ == TYPE_LOCAL) begin
      case (tag)
        TAG_USAGE: if (fill_q < NUM_USAGES) begin
          usages[fill_q] = accum[15:0];
          fill_q++;
        end
        TAG_UMIN: begin rlow_q = accum[15:0]; rseen_q = 1; end
        TAG_UMAX: begin rhigh_q = accum[15:0]; rseen_q = 1; end
        default: ;
      endcase
    end
  endfunction

  // advance the predictor by one byte and hand the records to the scoreboard
  function void predict_byte(logic [7:0] b, logic last);
    record_t r;
    out_batch.delete();
    case (ph)
      PH_PREFIX: begin
        if (b == LONG_PREFIX) ph = PH_LSIZE;
        else begin
          pfx = b; accum = 0; bidx = 0;
          left_cnt = (b[1:0] == 3) ? 4 : b[1:0];
          if (left_cnt == 0) exec_item();
          else ph = PH_DATA;
        end
      end
      PH_DATA: begin
        accum = accum | (32'(b) << (8 * bidx));
        bidx = bidx + 1;
        if (left_cnt > 0) left_cnt--;
        if (left_cnt == 0) begin
          ph = PH_PREFIX;
          exec_item();
        end
      end
      PH_LSIZE: begin left_cnt = b; ph = PH_LTAG; end
      PH_LTAG: ph = (left_cnt != 0) ? PH_LDATA : PH_PREFIX;
      default: begin
        if (left_cnt > 0) left_cnt--;
        if (left_cnt == 0) ph = PH_PREFIX;
      end
    endcase
    if (last) begin
      if (ph == PH_DATA) exec_item();
      for (int k = 0; k < 3; k++)
        push_rec(KIND_TOTAL_BASE + k, 0, offs[k], 0, 0, 0, 0, 0, MODE_NONE, 0, 0);
      clear_parse();
    end
    for (int i = 0; i < out_batch.size(); i++) begin
      r = out_batch[i];
      r.last_of_run = (i == out_batch.size() - 1);
      sb.note_record(r);
    end
  endfunction

  // stimulus queue built up front
  logic [8:0] stim[$];
  int idle_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stalls on a rotating pattern
  initial begin
    int cyc;
    cyc = 0;
    rec_out.ready <= 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 300 < 60) rec_out.ready <= 1;
      else if (cyc % 300 < 180) rec_out.ready <= ($urandom_range(0, 3) != 0);
      else rec_out.ready <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && rec_out.valid && rec_out.ready) sb.check_record(rec_out.payload);
    if (!rst && desc_in.valid && desc_in.ready)
      predict_byte(desc_in.payload.data_byte, desc_in.payload.last_byte);
    if ((desc_in.valid && desc_in.ready) || (rec_out.valid && rec_out.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task add_byte(int b, int last = 0);
    stim.insert(stim.size(), {b[7:0], last[0]});
  endtask

  task add_short(int typ, int tag, int nb, logic [31:0] d);
    int code;
    code = (nb == 4) ? 3 : nb;
    add_byte((tag << 4) | (typ << 2) | code);
    for (int i = 0; i < nb; i++) add_byte(d[8 * i +: 8]);
  endtask

  function int rand_nb();
    return $urandom_range(0, 3) == 3 ? 4 : $urandom_range(0, 2);
  endfunction

  // a random descriptor run, with some random bytes, ending with a last byte
  task add_descriptor();
    int n;
    n = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0: add_short(TYPE_GLOBAL, TAG_PAGE, rand_nb(), $urandom);
        1: add_short(TYPE_GLOBAL, TAG_LMIN, rand_nb(), $urandom);
        2: add_short(TYPE_GLOBAL, TAG_LMAX, rand_nb(), $urandom);
        3: add_short(TYPE_GLOBAL, TAG_RSIZE, $urandom_range(1, 2), $urandom_range(0, 300));
        4: add_short(TYPE_GLOBAL, TAG_RCOUNT, 1, $urandom_range(0, 20));
        5: add_short(TYPE_GLOBAL, TAG_RID, rand_nb(), $urandom);
        6: repeat ($urandom_range(1, 5)) add_short(TYPE_LOCAL, TAG_USAGE, rand_nb(), $urandom);
        7: begin
          add_short(TYPE_LOCAL, TAG_UMIN, rand_nb(), $urandom);
          if ($urandom_range(0, 3) != 0) add_short(TYPE_LOCAL, TAG_UMAX, rand_nb(), $urandom);
        end
        8, 9: begin
          int t;
          t = $urandom_range(0, 2);
          add_short(TYPE_MAIN, t == 0 ? TAG_INPUT : (t == 1 ? TAG_OUTPUT : TAG_FEATURE),
                    $urandom_range(0, 2), $urandom);
        end
        10: begin
          int ln;
          ln = $urandom_range(0, 3);
          add_byte(LONG_PREFIX); add_byte(ln); add_byte($urandom_range(0, 255));
          repeat (ln) add_byte($urandom_range(0, 255));
        end
        default: add_byte($urandom_range(0, 255));
      endcase
    end
    if ($urandom_range(0, 4) == 0) add_byte($urandom_range(0, 255), 1);
    else add_byte((TAG_INPUT << 4) | (TYPE_MAIN << 2), 1);
  endtask

  task send_all();
    int burst, k, gap;
    bit drained, do_drain;
    k = 0;
    drained = 0;
    while (k < stim.size()) begin
      burst = $urandom_range(1, 12);
      desc_in.valid <= 1;
      while (burst > 0 && k < stim.size()) begin
        desc_in.payload <= stim[k];
        @(posedge clk);
        while (!desc_in.ready) @(posedge clk);
        k++;
        burst--;
      end
      do_drain = !drained && (k >= stim.size() / 2);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 10) : 0;
      if (do_drain || gap > 0 || k == stim.size()) begin
        desc_in.valid <= 0;
        if (do_drain) begin
          // drain all pending records once mid-run
          drained = 1;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        repeat ((gap > 0) ? gap : 1) @(posedge clk);
      end
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    clear_parse();
    rst = 1;
    desc_in.valid <= 0;
    desc_in.payload <= '0;
    // directed: extremes, all main kinds, range, list overflow, long and truncated items
    add_short(TYPE_GLOBAL, TAG_PAGE, 2, 32'hFFFF);
    add_short(TYPE_GLOBAL, TAG_LMIN, 1, 32'h80);
    add_short(TYPE_GLOBAL, TAG_LMAX, 4, 32'h7FFFFFFF);
    add_short(TYPE_GLOBAL, TAG_RSIZE, 4, 32'hFFFFFFFF);
    add_short(TYPE_GLOBAL, TAG_RCOUNT, 1, 20);
    add_short(TYPE_GLOBAL, TAG_RID, 1, 8'hFF);
    repeat (18) add_short(TYPE_LOCAL, TAG_USAGE, 2, $urandom);
    add_short(TYPE_MAIN, TAG_INPUT, 1, 0);
    add_short(TYPE_LOCAL, TAG_UMIN, 1, 3);
    add_short(TYPE_LOCAL, TAG_UMAX, 1, 9);
    add_short(TYPE_MAIN, TAG_OUTPUT, 0, 0);
    add_short(TYPE_LOCAL, TAG_UMIN, 1, 9);
    add_short(TYPE_LOCAL, TAG_UMAX, 1, 3);
    add_short(TYPE_MAIN, TAG_FEATURE, 0, 0);
    add_byte(LONG_PREFIX); add_byte(2); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h01);
    add_short(TYPE_GLOBAL, TAG_LMIN, 0, 0);
    add_byte(8'h17); add_byte(8'hAB, 1);
    add_byte(8'h15, 1);
    add_byte(LONG_PREFIX); add_byte(5, 1);
    add_byte(8'hFF, 1);
    while (stim.size() < 380) add_descriptor();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_all();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
src/hidp_pkg.sv
src/hidp_if.sv
src/hidp_datapath.sv
src/hidp_ctrl.sv
src/hid_report_descriptor_parser.sv
tb/hid_report_descriptor_parser_tb.sv
